/* sv/sild_pkg.sv */
package sild_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WIN_BYTES = 6;
    localparam int unsigned WIN_W     = WIN_BYTES * BYTE_W;
    localparam int unsigned LEN_W     = 4;

    // Legacy prefixes, REX and escape
    localparam logic [7:0] PFX_OPSIZE = 8'h66;
    localparam logic [7:0] PFX_REPNE  = 8'hF2;
    localparam logic [7:0] PFX_REP    = 8'hF3;
    localparam logic [7:0] REX_MASK   = 8'hF0;
    localparam logic [7:0] REX_BASE   = 8'h40;
    localparam logic [7:0] ESC_0F     = 8'h0F;

    // Handled opcodes after the escape
    localparam logic [7:0] OP_CVTSI2S  = 8'h2A;
    localparam logic [7:0] OP_CVTTS2SI = 8'h2C;
    localparam logic [7:0] OP_CVTS2SI  = 8'h2D;
    localparam logic [7:0] OP_UCOMIS   = 8'h2E;
    localparam logic [7:0] OP_COMIS    = 8'h2F;
    localparam logic [7:0] OP_SQRT     = 8'h51;
    localparam logic [7:0] OP_ADD      = 8'h58;
    localparam logic [7:0] OP_MAX      = 8'h5F;
    localparam logic [7:0] OP_CMP      = 8'hC2;
    localparam logic [7:0] OP_CVTDQ    = 8'hE6;

    // mod field codes
    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;

    // r/m and SIB base codes
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_RIPREL  = 3'd5;
    localparam logic [2:0] BASE_NONE  = 3'd5;

    typedef struct packed {
        logic [LEN_W-1:0] insn_length;
        logic             unrecognized;
    } sild_result_t;

endpackage

/* sv/sild_if.sv */
interface sild_in_if;
    logic                       valid;
    logic                       ready;
    logic [sild_pkg::WIN_W-1:0] insn_bytes;

    modport source (output valid, output insn_bytes, input ready);
    modport sink   (input valid, input insn_bytes, output ready);
endinterface

interface sild_out_if;
    logic                       valid;
    logic                       ready;
    logic [sild_pkg::LEN_W-1:0] insn_length;
    logic                       unrecognized;

    modport source (output valid, output insn_length, output unrecognized, input ready);
    modport sink   (input valid, input insn_length, input unrecognized, output ready);
endinterface

/* sv/sild_decode.sv */
module sild_decode (
    input  logic                       long_mode,
    input  logic [sild_pkg::WIN_W-1:0] insn_bytes,
    output sild_pkg::sild_result_t     result
);
    import sild_pkg::*;

    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic [7:0]       b3;
    logic [7:0]       b4;
    logic [7:0]       b5;
    logic             has_pfx;
    logic [7:0]       after_pfx;
    logic             has_rex;
    logic [1:0]       esc_pos;
    logic [7:0]       esc;
    logic [7:0]       op;
    logic [7:0]       modrm;
    logic [7:0]       sib;
    logic             op_known;
    logic             has_imm;
    logic [1:0]       mode;
    logic [2:0]       rm;
    logic [LEN_W-1:0] tail_len;

    assign b0 = insn_bytes[7:0];
    assign b1 = insn_bytes[15:8];
    assign b2 = insn_bytes[23:16];
    assign b3 = insn_bytes[31:24];
    assign b4 = insn_bytes[39:32];
    assign b5 = insn_bytes[47:40];

    // Find the escape position past the optional prefix and REX
    assign has_pfx   = (b0 == PFX_OPSIZE) || (b0 == PFX_REPNE) || (b0 == PFX_REP);
    assign after_pfx = has_pfx ? b1 : b0;
    assign has_rex   = long_mode && ((after_pfx & REX_MASK) == REX_BASE);
    assign esc_pos   = {1'b0, has_pfx} + {1'b0, has_rex};

    // Select the escape, opcode, mod/rm and SIB bytes
    always_comb
    begin
        unique case (esc_pos)
            2'd0:
            begin
                esc = b0; op = b1; modrm = b2; sib = b3;
            end
            2'd1:
            begin
                esc = b1; op = b2; modrm = b3; sib = b4;
            end
            2'd2:
            begin
                esc = b2; op = b3; modrm = b4; sib = b5;
            end
            default:
            begin
                esc = b0; op = b1; modrm = b2; sib = b3;
            end
        endcase
    end

    // Match the opcode against the handled set
    always_comb
    begin
        op_known = 1'b1;
        has_imm  = 1'b0;
        unique case (op) inside
            OP_CVTSI2S, OP_CVTTS2SI, OP_CVTS2SI, OP_UCOMIS, OP_COMIS,
            OP_SQRT, [OP_ADD:OP_MAX], OP_CVTDQ:
                op_known = 1'b1;
            OP_CMP:
                has_imm = 1'b1;
            default:
                op_known = 1'b0;
        endcase
    end

    assign mode = modrm[7:6];
    assign rm   = modrm[2:0];

    // Add SIB, displacement and immediate bytes
    always_comb
    begin
        tail_len = {{(LEN_W-1){1'b0}}, has_imm};
        unique case (mode)
            MOD_NODISP:
            begin
                if (rm == RM_SIB)
                begin
                    tail_len = tail_len + LEN_W'(1);
                    if (sib[2:0] == BASE_NONE)
                        tail_len = tail_len + LEN_W'(4);
                end
                else if (rm == RM_RIPREL)
                begin
                    tail_len = tail_len + LEN_W'(4);
                end
            end
            MOD_DISP8:
            begin
                tail_len = tail_len + LEN_W'(1) + ((rm == RM_SIB) ? LEN_W'(1) : LEN_W'(0));
            end
            MOD_DISP32:
            begin
                tail_len = tail_len + LEN_W'(4) + ((rm == RM_SIB) ? LEN_W'(1) : LEN_W'(0));
            end
            MOD_REG:
            begin
                tail_len = tail_len;
            end
            default:
            begin
                tail_len = tail_len;
            end
        endcase
    end

    // Combine: escape, opcode and mod/rm are three bytes past the escape position
    always_comb
    begin
        if ((esc != ESC_0F) || !op_known)
        begin
            result.insn_length  = '0;
            result.unrecognized = 1'b1;
        end
        else
        begin
            result.insn_length  = {{(LEN_W-2){1'b0}}, esc_pos} + LEN_W'(3) + tail_len;
            result.unrecognized = 1'b0;
        end
    end

endmodule

/* sv/sse2_insn_length_decoder.sv */
// Pipeline: input register, decode, result register; result.ready low with
// a full result stage stalls it. Throughput: one item per cycle when not
// stalled; the decode is one pass over the byte window.
// Reset: rst_n clears both stage valid flags and sets long_mode to 1.
module sse2_insn_length_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        long_mode_we,
    input  logic        long_mode_wdata,
    sild_in_if.sink     insn,
    sild_out_if.source  result
);
    import sild_pkg::*;

    logic             long_mode_reg;
    logic             in_valid_reg;
    logic [WIN_W-1:0] in_bytes_reg;
    logic             out_valid_reg;
    sild_result_t     out_reg;
    sild_result_t     dec_result;
    logic             out_load;
    logic             in_load;

    // Advance the result stage when it is empty or being taken
    assign out_load   = !out_valid_reg || result.ready;
    assign in_load    = !in_valid_reg || out_load;
    assign insn.ready = in_load;

    // Hold the mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            long_mode_reg <= 1'b1;
        else if (long_mode_we)
            long_mode_reg <= long_mode_wdata;
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_load)
            in_valid_reg <= insn.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_load && insn.valid)
            in_bytes_reg <= insn.insn_bytes;
    end

    sild_decode u_decode (
        .long_mode  (long_mode_reg),
        .insn_bytes (in_bytes_reg),
        .result     (dec_result)
    );

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
            out_reg <= dec_result;
    end

    assign result.valid        = out_valid_reg;
    assign result.insn_length  = out_reg.insn_length;
    assign result.unrecognized = out_reg.unrecognized;

endmodule

/* tb/sild_length_checker.sv */
module sild_length_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic long_mode_we,
    input  logic long_mode_wdata,
    sild_in_if   insn,
    sild_out_if  result,
    output int   error_count,
    output int   pending_count
);
    import sild_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [WIN_W-1:0] window;
        sild_result_t     outcome;
    } decoded_insn_t;

    decoded_insn_t expected_lengths [$];
    logic          long_mode_q;

    // Work out the length of one instruction window under the given mode
    function automatic sild_result_t decode_length(input logic [WIN_W-1:0] window,
                                                   input logic rex_ok);
        sild_result_t res;
        int unsigned  idx;
        int unsigned  extra;
        logic [7:0]   cur;
        logic [7:0]   modrm;
        logic [7:0]   sib;
        logic         op_ok;
        logic         has_imm;

        res.insn_length  = '0;
        res.unrecognized = 1'b1;
        idx = 0;
        cur = window[7:0];

        // Skip one legacy prefix, then one REX byte in long mode
        if (cur == PFX_OPSIZE || cur == PFX_REPNE || cur == PFX_REP)
        begin
            idx++;
            cur = window[idx*8 +: 8];
        end
        if (rex_ok && (cur & REX_MASK) == REX_BASE)
        begin
            idx++;
            cur = window[idx*8 +: 8];
        end
        if (cur != ESC_0F)
            return res;

        // Opcode must be in the handled set; compare carries an immediate
        idx++;
        cur = window[idx*8 +: 8];
        has_imm = (cur == OP_CMP);
        case (cur)
            OP_CVTSI2S, OP_CVTTS2SI, OP_CVTS2SI, OP_UCOMIS, OP_COMIS,
            OP_SQRT, OP_CVTDQ, OP_CMP:
                op_ok = 1'b1;
            default:
                op_ok = (cur >= OP_ADD && cur <= OP_MAX);
        endcase
        if (!op_ok)
            return res;

        // Walk mod/rm and SIB to size the displacement
        idx++;
        modrm = window[idx*8 +: 8];
        idx++;
        extra = has_imm ? 1 : 0;
        case (modrm[7:6])
            MOD_NODISP:
            begin
                if (modrm[2:0] == RM_SIB)
                begin
                    sib = window[idx*8 +: 8];
                    idx++;
                    if (sib[2:0] == BASE_NONE)
                        extra += 4;
                end
                else if (modrm[2:0] == RM_RIPREL)
                    extra += 4;
            end
            MOD_DISP8:
            begin
                extra += 1;
                if (modrm[2:0] == RM_SIB)
                    idx++;
            end
            MOD_DISP32:
            begin
                extra += 4;
                if (modrm[2:0] == RM_SIB)
                    idx++;
            end
            default:
                ;
        endcase

        res.insn_length  = LEN_W'(idx + extra);
        res.unrecognized = 1'b0;
        return res;
    endfunction

    // Track the mode register as the block sees it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            long_mode_q <= 1'b1;
        else if (long_mode_we)
            long_mode_q <= long_mode_wdata;
    end

    // Match each result against the oldest decoded item, then queue new items
    always @(posedge clk)
    begin
        decoded_insn_t head;
        decoded_insn_t entry;

        if (!rst_n)
        begin
            expected_lengths.delete();
            error_count   = 0;
            pending_count = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_lengths.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result length %0d unrecognized %0b",
                                 $realtime, result.insn_length, result.unrecognized);
                end
                else
                begin
                    head = expected_lengths.pop_front();
                    if (result.insn_length !== head.outcome.insn_length ||
                        result.unrecognized !== head.outcome.unrecognized)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: bytes %h: expected %0d/%0b, got %0d/%0b",
                                     $realtime, head.window, head.outcome.insn_length,
                                     head.outcome.unrecognized, result.insn_length,
                                     result.unrecognized);
                    end
                end
            end

            if (insn.valid && insn.ready)
            begin
                entry.window  = insn.insn_bytes;
                entry.outcome = decode_length(insn.insn_bytes, long_mode_q);
                expected_lengths.push_back(entry);
            end

            pending_count = expected_lengths.size();
        end
    end

endmodule

/* tb/tb_sse2_insn_length_decoder.sv */
module tb_sse2_insn_length_decoder;
    import sild_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 20;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;

    logic clk             = 1'b0;
    logic rst_n           = 1'b0;
    logic long_mode_we    = 1'b0;
    logic long_mode_wdata = 1'b0;

    int   error_count;
    int   pending_count;
    bit   steady_flow;
    int   hold_asks;
    logic lm_shadow;
    logic [7:0] handled_ops [16];

    sild_in_if  insn_ch ();
    sild_out_if result_ch ();

    sse2_insn_length_decoder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .long_mode_we    (long_mode_we),
        .long_mode_wdata (long_mode_wdata),
        .insn            (insn_ch),
        .result          (result_ch)
    );

    sild_length_checker length_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .long_mode_we    (long_mode_we),
        .long_mode_wdata (long_mode_wdata),
        .insn            (insn_ch),
        .result          (result_ch),
        .error_count     (error_count),
        .pending_count   (pending_count)
    );

    always #CLK_HALF clk = ~clk;

    // Lay out prefix, REX, escape, opcode, mod/rm and SIB over a filler window
    function automatic logic [WIN_W-1:0] encode_insn(input bit has_pfx, input logic [7:0] pfx,
                                                     input bit has_rex, input logic [7:0] rex,
                                                     input logic [7:0] esc,
                                                     input logic [7:0] op,
                                                     input logic [7:0] modrm,
                                                     input logic [7:0] sib,
                                                     input logic [WIN_W-1:0] filler);
        logic [WIN_W-1:0] window;
        int unsigned      idx;

        window = filler;
        idx = 0;
        if (has_pfx)
        begin
            window[idx*8 +: 8] = pfx;
            idx++;
        end
        if (has_rex)
        begin
            window[idx*8 +: 8] = rex;
            idx++;
        end
        window[idx*8 +: 8] = esc;
        window[(idx+1)*8 +: 8] = op;
        window[(idx+2)*8 +: 8] = modrm;
        window[(idx+3)*8 +: 8] = sib;
        return window;
    endfunction

    // Mostly well-formed instructions with random content, some noise and breakage
    function automatic logic [WIN_W-1:0] random_insn(input logic lm);
        logic [63:0] noise;
        logic [7:0]  pfx;
        logic [7:0]  rex;
        logic [7:0]  esc;
        logic [7:0]  op;
        bit          has_pfx;
        bit          has_rex;
        int          pick;

        pick  = $urandom_range(99);
        noise = {$urandom, $urandom};
        if (pick < 15)
            return noise[WIN_W-1:0];

        has_pfx = 1'($urandom_range(1));
        case ($urandom_range(2))
            0:       pfx = PFX_OPSIZE;
            1:       pfx = PFX_REPNE;
            default: pfx = PFX_REP;
        endcase
        has_rex = ($urandom_range(99) < (lm ? 50 : 15));
        rex = REX_BASE | 8'($urandom_range(15));
        esc = ESC_0F;
        op  = handled_ops[$urandom_range(15)];

        // Break one part of the sequence
        if (pick < 27)
        begin
            case ($urandom_range(2))
                0: esc = 8'($urandom_range(255));
                1: op  = 8'($urandom_range(255));
                default:
                begin
                    has_pfx = 1'b1;
                    has_rex = 1'b1;
                    rex     = pfx;
                end
            endcase
        end

        return encode_insn(has_pfx, pfx, has_rex, rex, esc, op,
                           8'($urandom_range(255)), 8'($urandom_range(255)),
                           noise[WIN_W-1:0]);
    endfunction

    // Offer one item after an optional idle gap, hold until accepted
    task automatic offer_insn(input logic [WIN_W-1:0] window);
        if (!steady_flow)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                insn_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        insn_ch.valid      <= 1'b1;
        insn_ch.insn_bytes <= window;
        do
            @(posedge clk);
        while (!insn_ch.ready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every queued item has come back
    task automatic wait_idle();
        insn_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_long_mode(input logic value);
        long_mode_we    <= 1'b1;
        long_mode_wdata <= value;
        @(negedge clk);
        long_mode_we    <= 1'b0;
        lm_shadow = value;
    endtask

    // Result side: random stalls, steady stretches and one long hold-off
    initial
    begin
        int hold_left;
        int holds_done;

        result_ch.ready = 1'b0;
        hold_left  = 0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (holds_done != hold_asks)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else if (steady_flow)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Bound the run
    initial
    begin
        int cycle_count;

        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [7:0] pfx;
        logic [7:0] modrm;

        insn_ch.valid      = 1'b0;
        insn_ch.insn_bytes = '0;
        steady_flow = 1'b0;
        hold_asks   = 0;
        lm_shadow   = 1'b1;
        handled_ops = '{OP_CVTSI2S, OP_CVTTS2SI, OP_CVTS2SI, OP_UCOMIS, OP_COMIS, OP_SQRT,
                        OP_ADD, OP_ADD + 8'd1, OP_ADD + 8'd2, OP_ADD + 8'd3, OP_ADD + 8'd4,
                        OP_ADD + 8'd5, OP_ADD + 8'd6, OP_MAX, OP_CMP, OP_CVTDQ};

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Every opcode, rotating through prefixes, REX and addressing forms
        for (int k = 0; k < 16; k++)
        begin
            case (k % 4)
                1:       pfx = PFX_OPSIZE;
                2:       pfx = PFX_REPNE;
                default: pfx = PFX_REP;
            endcase
            case (k % 8)
                0:       modrm = 8'hC0;
                1:       modrm = 8'h00;
                2:       modrm = 8'h04;
                3:       modrm = 8'h05;
                4:       modrm = 8'h44;
                5:       modrm = 8'h45;
                6:       modrm = 8'h84;
                default: modrm = 8'h80;
            endcase
            offer_insn(encode_insn(k % 4 != 0, pfx, k % 3 == 0, REX_BASE | 8'(k), ESC_0F,
                                   handled_ops[k], modrm, (k % 2 == 0) ? 8'h25 : 8'h3C,
                                   (k % 2 == 1) ? {WIN_W{1'b1}} : {WIN_W{1'b0}}));
        end

        // Longest form, missing escape, unknown opcode, second prefix, all-zero and all-one
        offer_insn(encode_insn(1'b1, PFX_REP, 1'b1, REX_BASE | 8'h0F, ESC_0F, OP_CMP,
                               8'h84, 8'hFF, '1));
        offer_insn(encode_insn(1'b1, PFX_OPSIZE, 1'b0, REX_BASE, ESC_0F + 8'd1, OP_ADD,
                               8'hC0, 8'h00, '0));
        offer_insn(encode_insn(1'b0, PFX_OPSIZE, 1'b0, REX_BASE, ESC_0F, OP_ADD - 8'd1,
                               8'hC0, 8'h00, '0));
        offer_insn(encode_insn(1'b1, PFX_OPSIZE, 1'b1, PFX_REPNE, ESC_0F, OP_ADD,
                               8'hC0, 8'h00, '0));
        offer_insn('0);
        offer_insn('1);

        // Legacy mode: REX where the escape belongs is rejected
        wait_idle();
        write_long_mode(1'b0);
        offer_insn(encode_insn(1'b0, PFX_OPSIZE, 1'b1, REX_BASE | 8'h08, ESC_0F, OP_ADD,
                               8'hC0, 8'h00, '0));
        offer_insn(encode_insn(1'b1, PFX_OPSIZE, 1'b1, REX_BASE | 8'h01, ESC_0F, OP_SQRT,
                               8'h00, 8'h00, '1));
        offer_insn(encode_insn(1'b0, PFX_OPSIZE, 1'b0, REX_BASE, ESC_0F, OP_ADD,
                               8'hC0, 8'h00, '0));
        for (int n = 0; n < 250; n++)
            offer_insn(random_insn(lm_shadow));

        // Long mode with a steady stretch, then a long result hold-off
        wait_idle();
        write_long_mode(1'b1);
        for (int n = 0; n < 300; n++)
        begin
            steady_flow = (n < 120);
            if (n == 150)
                hold_asks++;
            offer_insn(random_insn(lm_shadow));
        end

        wait_idle();
        write_long_mode(1'b0);
        for (int n = 0; n < 250; n++)
            offer_insn(random_insn(lm_shadow));

        wait_idle();
        if (error_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
sv/sild_pkg.sv
sv/sild_if.sv
sv/sild_decode.sv
sv/sse2_insn_length_decoder.sv
tb/sild_length_checker.sv
tb/tb_sse2_insn_length_decoder.sv
